@@ rtl/rlpm_pkg.sv @@
// rlpm_pkg: shared types, codes and widths for the range list parser and matcher
// no dependencies
package rlpm_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int VALUE_BITS_DEF  = 32;

    localparam int CHAR_W    = 8;
    localparam int QUERY_W   = 32;
    localparam int ERR_W     = 3;
    localparam int COUNT_W   = 5;
    localparam int OUT_BITS  = 1 + ERR_W + COUNT_W;
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 16;

    localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_HYPHEN = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;

    typedef enum logic [1:0] {
        MODE_TEXT  = 2'd0,
        MODE_END   = 2'd1,
        MODE_QUERY = 2'd2,
        MODE_NOP   = 2'd3
    } mode_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK       = 3'd0,
        ERR_BADCHAR  = 3'd1,
        ERR_EMPTY    = 3'd2,
        ERR_ORDER    = 3'd3,
        ERR_FULL     = 3'd4,
        ERR_OVERFLOW = 3'd5,
        ERR_HYPHEN2  = 3'd6
    } err_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic scan_run;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic is_query;
        logic scan_done;
    } sts_t;

endpackage

@@ rtl/rlpm_ctrl.sv @@
// rlpm_ctrl: request sequencing state machine and output valid
// depends on rlpm_pkg
module rlpm_ctrl
    import rlpm_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_tvalid,
    output logic   s_tready,
    output logic   m_tvalid,
    input  logic   m_tready,
    input  sts_t   sts,
    output cmd_t   cmd
);

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                state_next = sts.is_query ? ST_SCAN : ST_EMIT;
            end
            ST_SCAN: begin
                if (sts.scan_done) state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd           = '0;
        s_tready      = 1'b0;
        m_tvalid_next = m_tready ? 1'b0 : m_tvalid_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
            end
            ST_SCAN: begin
                cmd.scan_run = 1'b1;
            end
            ST_EMIT: begin
                cmd.emit = out_free;
                if (out_free) m_tvalid_next = 1'b1;
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

@@ rtl/rlpm_dp.sv @@
// rlpm_dp: text parser, interval table memory, membership scan and result register
// depends on rlpm_pkg
module rlpm_dp
    import rlpm_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int PW = VALUE_BITS + 4;
    localparam logic [VALUE_BITS-1:0] VMAX = '1;

    mode_t                  mode_reg;
    logic [CHAR_W-1:0]      char_reg;
    logic                   first_reg;
    logic [QUERY_W-1:0]     query_reg;

    logic [VALUE_BITS-1:0]  acc_reg, acc_next;
    logic                   seen_reg, seen_next;
    logic [VALUE_BITS-1:0]  start_reg, start_next;
    logic                   open_reg, open_next;
    logic [CW-1:0]          count_reg, count_next;

    logic [2*VALUE_BITS-1:0] mem [TABLE_DEPTH];
    logic [2*VALUE_BITS-1:0] rd_data_reg;
    logic                    rd_valid_reg;
    logic [CW-1:0]           idx_reg;
    logic                    hit_reg;
    err_t                    err_reg, err_next;

    logic                    out_hit_reg;
    err_t                    out_err_reg;
    logic [COUNT_W-1:0]      out_count_reg;

    logic                    clr, parse_step, at_end, close_now, is_digit;
    logic [VALUE_BITS-1:0]   acc_e, start_e, lo, hi;
    logic                    seen_e, open_e, have_item, wr_en;
    logic [CW-1:0]           cnt_e;
    logic [3:0]              digit_val;
    logic [PW-1:0]           prod;
    logic                    overflow, issue, in_range;
    logic [VALUE_BITS-1:0]   rd_lo, rd_hi;

    // parse step
    always_comb begin
        parse_step = (mode_reg == MODE_TEXT) || (mode_reg == MODE_END);
        clr        = first_reg && parse_step;
        at_end     = (mode_reg == MODE_END);
        acc_e      = clr ? '0 : acc_reg;
        seen_e     = clr ? 1'b0 : seen_reg;
        start_e    = clr ? '0 : start_reg;
        open_e     = clr ? 1'b0 : open_reg;
        cnt_e      = clr ? '0 : count_reg;
        is_digit   = (char_reg >= CH_ZERO) && (char_reg <= CH_NINE);
        digit_val  = 4'(char_reg - CH_ZERO);
        prod       = PW'({acc_e, 3'b000}) + PW'({acc_e, 1'b0}) + PW'(digit_val);
        overflow   = (prod[PW-1:VALUE_BITS] != '0);
        close_now  = at_end || ((mode_reg == MODE_TEXT) && (char_reg == CH_COMMA));

        have_item = 1'b0;
        lo        = acc_e;
        hi        = acc_e;
        if (seen_e) begin
            have_item = 1'b1;
            lo        = open_e ? start_e : acc_e;
        end else if (open_e && at_end) begin
            have_item = 1'b1;
            lo        = start_e;
            hi        = VMAX;
        end

        wr_en      = 1'b0;
        acc_next   = acc_e;
        seen_next  = seen_e;
        start_next = start_e;
        open_next  = open_e;
        err_next   = ERR_OK;

        if (close_now) begin
            acc_next   = '0;
            seen_next  = 1'b0;
            start_next = '0;
            open_next  = 1'b0;
            priority if (!have_item) begin
                err_next = at_end ? ERR_OK : ERR_EMPTY;
            end else if (lo > hi) begin
                err_next = ERR_ORDER;
            end else if (cnt_e >= CW'(TABLE_DEPTH)) begin
                err_next = ERR_FULL;
            end else begin
                wr_en = 1'b1;
            end
        end else if (is_digit) begin
            if (overflow) begin
                err_next = ERR_OVERFLOW;
            end else begin
                acc_next  = prod[VALUE_BITS-1:0];
                seen_next = 1'b1;
            end
        end else if (char_reg == CH_HYPHEN) begin
            priority if (open_e) begin
                err_next = ERR_HYPHEN2;
            end else if (!seen_e) begin
                err_next = ERR_EMPTY;
            end else begin
                start_next = acc_e;
                open_next  = 1'b1;
                acc_next   = '0;
                seen_next  = 1'b0;
            end
        end else begin
            err_next = ERR_BADCHAR;
        end

        count_next = wr_en ? cnt_e + CW'(1) : cnt_e;
    end

    // scan
    assign issue    = cmd.scan_run && !hit_reg && (idx_reg < count_reg);
    assign rd_lo    = rd_data_reg[VALUE_BITS-1:0];
    assign rd_hi    = rd_data_reg[2*VALUE_BITS-1:VALUE_BITS];
    assign in_range = (query_reg >= QUERY_W'(rd_lo)) && (query_reg <= QUERY_W'(rd_hi));

    assign sts.is_query  = (mode_reg == MODE_QUERY);
    assign sts.scan_done = !issue && !rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            char_reg  <= s_tdata[CHAR_W-1:0];
            query_reg <= s_tdata[CHAR_W +: QUERY_W];
            mode_reg  <= mode_t'(s_tuser[1:0]);
            first_reg <= s_tuser[2];
        end
        if (cmd.exec) begin
            err_reg <= parse_step ? err_next : ERR_OK;
        end
        if (cmd.emit) begin
            out_hit_reg   <= (mode_reg == MODE_QUERY) && hit_reg;
            out_err_reg   <= err_reg;
            out_count_reg <= COUNT_W'(count_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec && parse_step && wr_en) begin
            mem[cnt_e[AW-1:0]] <= {hi, lo};
        end
        if (issue) begin
            rd_data_reg <= mem[idx_reg[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg      <= '0;
            seen_reg     <= 1'b0;
            start_reg    <= '0;
            open_reg     <= 1'b0;
            count_reg    <= '0;
            idx_reg      <= '0;
            rd_valid_reg <= 1'b0;
            hit_reg      <= 1'b0;
        end else begin
            if (cmd.exec && parse_step) begin
                acc_reg   <= acc_next;
                seen_reg  <= seen_next;
                start_reg <= start_next;
                open_reg  <= open_next;
                count_reg <= count_next;
            end
            if (cmd.load_in) begin
                idx_reg      <= '0;
                rd_valid_reg <= 1'b0;
                hit_reg      <= 1'b0;
            end else if (cmd.scan_run) begin
                if (issue) idx_reg <= idx_reg + CW'(1);
                rd_valid_reg <= issue;
                if (rd_valid_reg && in_range) hit_reg <= 1'b1;
            end
        end
    end

    assign m_tdata = {{(M_TDATA_W - OUT_BITS){1'b0}}, out_count_reg, out_err_reg, out_hit_reg};

endmodule

@@ rtl/range_list_parser_and_matcher.sv @@
// range_list_parser_and_matcher: top level, controller plus datapath
// depends on rlpm_pkg, rlpm_ctrl, rlpm_dp
//
//  channel | dir | ports                       | contents
//  s_      | in  | s_tvalid s_tready s_tdata   | tdata: char_code, query_index
//          |     | s_tuser                     | tuser: mode, first_char
//  m_      | out | m_tvalid m_tready m_tdata   | tdata: hit, error_code, entry_count
//
// text character and end of text: the request passes through the EXEC and EMIT states and
//   the result is registered in EMIT; the next request is taken only after EMIT
// query: entries are read one per cycle through the single table read port,
//   and the scan stops early on a hit
// reset is synchronous; the interval table itself is not cleared, only the count
// a stalled result waits in the output register while the next request is taken
module range_list_parser_and_matcher
    import rlpm_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // char_code[7:0], query_index[39:8]
    input  logic [S_TUSER_W-1:0] s_tuser,   // mode[1:0], first_char[2]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // hit[0], error_code[3:1], entry_count[8:4]
);

    cmd_t cmd;
    sts_t sts;

    rlpm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rlpm_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_BITS  (VALUE_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sts     (sts),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata)
    );

endmodule

@@ rtl/rlpm_chk.sv @@
// rlpm_chk: port level checks for range_list_parser_and_matcher, with bind
// depends on rlpm_pkg
module rlpm_chk
    import rlpm_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic [S_TUSER_W-1:0] s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // one request in flight
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while another is in flight");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_err_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[3:1] <= ERR_HYPHEN2)
        else $error("undefined error code");

    a_err_no_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[3:1] != ERR_OK) |-> !m_tdata[0])
        else $error("hit reported with an error");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind range_list_parser_and_matcher rlpm_chk u_chk (.*);
